// ----- rtl/stq_pkg.sv -----
// Shared codes and widths for the same-track request queue.
package stq_pkg;

    localparam int STATUS_BITS = 2;

    localparam logic [0:0] REQ_ADD = 1'b0;
    localparam logic [0:0] REQ_GET = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    localparam int OUT_USER_BITS = 1 + STATUS_BITS;

    typedef logic [STATUS_BITS-1:0] status_t;

endpackage

// ----- rtl/stq_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/same_track_request_queue_unit.sv -----
// Top level of the same-track disk request queue.
//
// Input stream (s_axis): s_axis_tuser selects the request, add or get.
// s_axis_tdata carries the tag and track of an add. One result transfer
// leaves on m_axis for every input transfer: the removed head on a get,
// the status (ok, dropped because full, get on empty) and the fill level.
// Entries sit in a circular buffer in one RAM; a get reads the head and
// advances the head pointer, an add walks the entries from the head to
// find the end of the first run of equal tracks, moves the entries behind
// that point up by one, then writes the new one.
// Sequence: a get passes the get-wait state before the result state, a
// rejected request goes straight to it; an add scans, shifts and inserts
// (with fewer than two entries it goes straight to insert), N entries
// scanned (at most the fill level) and M entries moved, both one per cycle
// through the single RAM read port; N + M is at most the fill level plus one.
// One request is in work at a time; s_axis_tready is high only when the
// sequencer is idle. The result sits in an output register, so the next
// request is accepted while it waits; a stalled m_axis holds the result
// and the sequencer waits before it posts the next one.
// Reset empties the queue at once; no clearing pass is needed.
module same_track_request_queue_unit #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TRACK_BITS  = 10,
    parameter int TAG_BITS    = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // request_tag, track
    input  logic [((TAG_BITS+TRACK_BITS+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic [0:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_tag, out_track, fill_level
    output logic [((TAG_BITS+TRACK_BITS+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // out_valid, status
    output logic [stq_pkg::OUT_USER_BITS-1:0]     m_axis_tuser
);

    import stq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = TAG_BITS + TRACK_BITS;
    localparam int MW = ((DW + CW + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_GET_WAIT = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SHIFT    = 3'd3;
    localparam logic [2:0] ST_INSERT   = 3'd4;
    localparam logic [2:0] ST_RESULT   = 3'd5;

    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [TRACK_BITS-1:0] trk_reg, trk_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       chk_reg, chk_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                rv_reg, rv_next;
    logic                prev_match_reg, prev_match_next;

    logic [TAG_BITS-1:0]   res_tag_reg, res_tag_next;
    logic [TRACK_BITS-1:0] res_trk_reg, res_trk_next;
    logic                  res_valid_reg, res_valid_next;
    status_t               res_status_reg, res_status_next;

    logic                     m_valid_reg, m_valid_next;
    logic [MW-1:0]            m_data_reg, m_data_next;
    logic [OUT_USER_BITS-1:0] m_user_reg, m_user_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic [AW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic [TRACK_BITS-1:0] rd_trk;
    logic [TAG_BITS-1:0]   rd_tag;

    logic                  s_accept;
    logic                  cur_eq;
    logic                  scan_hit;
    logic                  scan_end;

    stq_ram #(
        .WIDTH(DW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_trk   = rd_data[TRACK_BITS-1:0];
    assign rd_tag   = rd_data[DW-1:TRACK_BITS];
    assign s_accept = s_axis_tvalid && (state_reg == ST_IDLE);
    assign cur_eq   = (rd_trk == trk_reg);
    assign scan_hit = rv_reg && (chk_reg != '0) && prev_match_reg && !cur_eq;
    assign scan_end = rv_reg && (chk_reg == count_reg - ONE_C);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        tag_next        = tag_reg;
        trk_next        = trk_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        chk_next        = chk_reg;
        left_next       = left_reg;
        rv_next         = rv_reg;
        prev_match_next = prev_match_reg;
        res_tag_next    = res_tag_reg;
        res_trk_next    = res_trk_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, pos_reg);
        wr_data         = {tag_reg, trk_reg};
        rd_addr         = head_reg;

        case (state_reg)
            ST_IDLE: begin
                rd_addr = head_reg;
                if (s_accept) begin
                    tag_next     = s_axis_tdata[TAG_BITS-1:0];
                    trk_next     = s_axis_tdata[TAG_BITS +: TRACK_BITS];
                    res_tag_next = '0;
                    res_trk_next = '0;
                    res_valid_next  = 1'b0;
                    res_status_next = STATUS_OK;
                    if (s_axis_tuser == REQ_GET) begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_RESULT;
                        end else begin
                            state_next = ST_GET_WAIT;
                        end
                    end else if (count_reg == DEPTH_C) begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_RESULT;
                    end else if (count_reg < TWO_C) begin
                        pos_next   = count_reg;
                        state_next = ST_INSERT;
                    end else begin
                        idx_next        = '0;
                        rv_next         = 1'b0;
                        prev_match_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_GET_WAIT: begin
                res_tag_next    = rd_tag;
                res_trk_next    = rd_trk;
                res_valid_next  = 1'b1;
                res_status_next = STATUS_OK;
                head_next       = phys(head_reg, ONE_C);
                count_next      = count_reg - ONE_C;
                state_next      = ST_RESULT;
            end
            ST_SCAN: begin
                rd_addr  = phys(head_reg, idx_reg);
                rv_next  = 1'b1;
                chk_next = idx_reg;
                if (idx_reg < count_reg) begin
                    idx_next = idx_reg + ONE_C;
                end
                if (rv_reg) begin
                    prev_match_next = cur_eq;
                end
                if (scan_hit || scan_end) begin
                    pos_next   = scan_hit ? chk_reg : count_reg;
                    left_next  = count_reg - (scan_hit ? chk_reg : count_reg);
                    idx_next   = count_reg - ONE_C;
                    rv_next    = 1'b0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                rd_addr = phys(head_reg, idx_reg);
                if (left_reg != '0) begin
                    idx_next  = idx_reg - ONE_C;
                    left_next = left_reg - ONE_C;
                    chk_next  = idx_reg;
                    rv_next   = 1'b1;
                end else begin
                    rv_next = 1'b0;
                end
                if (rv_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = phys(head_reg, chk_reg + ONE_C);
                    wr_data = rd_data;
                end
                if (left_reg == '0 && !rv_reg) begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                wr_en           = 1'b1;
                wr_addr         = phys(head_reg, pos_reg);
                wr_data         = {tag_reg, trk_reg};
                count_next      = count_reg + ONE_C;
                res_status_next = STATUS_OK;
                state_next      = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next                      = 1'b1;
                    m_data_next                       = '0;
                    m_data_next[TAG_BITS-1:0]         = res_tag_reg;
                    m_data_next[TAG_BITS +: TRACK_BITS] = res_trk_reg;
                    m_data_next[DW +: CW]             = count_reg;
                    m_user_next                       = {res_status_reg, res_valid_reg};
                    state_next                        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rv_reg      <= rv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg        <= tag_next;
        trk_reg        <= trk_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        chk_reg        <= chk_next;
        left_reg       <= left_next;
        prev_match_reg <= prev_match_next;
        res_tag_reg    <= res_tag_next;
        res_trk_reg    <= res_trk_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && rv_reg) |-> chk_reg < count_reg)
        else $error("scan index beyond fill level");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_SHIFT || state_reg == ST_INSERT))
        else $error("RAM write outside insert sequence");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tuser == REQ_ADD && count_reg == DEPTH_C)
        |=> (state_reg == ST_RESULT && res_status_reg == STATUS_FULL
             && count_reg == DEPTH_C))
        else $error("add to full queue not dropped");

    a_get_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GET_WAIT) |=> count_reg == $past(count_reg) - ONE_C)
        else $error("get did not remove one entry");

endmodule

// ----- tb/sv/tb_same_track_request_queue_unit.sv -----
// Testbench for the same-track request queue: random bursty stimulus, scoreboard check.
`timescale 1ns / 100ps

module tb_same_track_request_queue_unit;
    import stq_pkg::*;

    localparam int QUEUE_DEPTH   = 64;
    localparam int TRACK_BITS    = 10;
    localparam int TAG_BITS      = 16;
    localparam int FILL_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_BITS  = ((TAG_BITS + TRACK_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((TAG_BITS + TRACK_BITS + FILL_BITS + 7) / 8) * 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASE_COUNT   = 8;
    localparam int DRAIN_CYCLES  = 300;

    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [TRACK_BITS-1:0] track_t;

    typedef struct packed {
        tag_t                 tag;
        track_t               track;
        logic [FILL_BITS-1:0] fill;
        logic                 valid;
        status_t              status;
    } queue_result_t;

    class track_queue_model;
        tag_t          entry_tags[$];
        track_t        entry_tracks[$];
        queue_result_t expected_results[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // predict the result of one accepted request
        function void note_request(logic [0:0] kind, tag_t tag, track_t track);
            queue_result_t r;
            int            held;
            int            slot;
            r = '0;
            held = entry_tags.size();
            if (kind == REQ_ADD) begin
                if (held >= QUEUE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    // end of the first run of equal tracks, else the tail
                    slot = held;
                    for (int i = 0; i + 1 < held && slot == held; i++)
                        if (entry_tracks[i] == track && entry_tracks[i+1] != track)
                            slot = i + 1;
                    entry_tags.insert(slot, tag);
                    entry_tracks.insert(slot, track);
                    r.status = STATUS_OK;
                end
            end else if (held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.tag    = entry_tags.pop_front();
                r.track  = entry_tracks.pop_front();
                r.valid  = 1'b1;
                r.status = STATUS_OK;
            end
            r.fill = FILL_BITS'(entry_tags.size());
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_BITS-1:0] data,
                                   logic [OUT_USER_BITS-1:0] user);
            queue_result_t exp_r;
            tag_t          got_tag;
            track_t        got_track;
            logic [FILL_BITS-1:0] got_fill;
            logic          got_valid;
            status_t       got_status;
            got_tag    = data[TAG_BITS-1:0];
            got_track  = data[TAG_BITS +: TRACK_BITS];
            got_fill   = data[TAG_BITS + TRACK_BITS +: FILL_BITS];
            got_valid  = user[0];
            got_status = user[1 +: STATUS_BITS];
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: tag %0h track %0h",
                       got_tag, got_track);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got_tag !== exp_r.tag) begin
                $error("out_tag: expected %0h, got %0h", exp_r.tag, got_tag);
                errors++;
            end
            if (got_track !== exp_r.track) begin
                $error("out_track: expected %0h, got %0h", exp_r.track, got_track);
                errors++;
            end
            if (got_fill !== exp_r.fill) begin
                $error("fill_level: expected %0d, got %0d", exp_r.fill, got_fill);
                errors++;
            end
            if (got_valid !== exp_r.valid) begin
                $error("out_valid: expected %0d, got %0d", exp_r.valid, got_valid);
                errors++;
            end
            if (got_status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got_status);
                errors++;
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_DATA_BITS-1:0]    s_axis_tdata;   // request_tag, track
    logic [0:0]                 s_axis_tuser;   // req_type
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_DATA_BITS-1:0]   m_axis_tdata;   // out_tag, out_track, fill_level
    logic [OUT_USER_BITS-1:0]   m_axis_tuser;   // out_valid, status

    track_queue_model queue_model;
    int               burst_left;
    track_t           track_pool[4];

    same_track_request_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TRACK_BITS (TRACK_BITS),
        .TAG_BITS   (TAG_BITS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            queue_model.note_request(s_axis_tuser, s_axis_tdata[TAG_BITS-1:0],
                                     s_axis_tdata[TAG_BITS +: TRACK_BITS]);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            queue_model.check_result(m_axis_tdata, m_axis_tuser);
    end

    // receiver: ready runs broken by stalls of random length
    initial begin
        int hold;
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            hold = $urandom_range(1, 40);
            repeat (hold) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge aclk);
            end
        end
    end

    // one transfer; bursts of random length with random gaps between them
    task automatic send_request(input logic [0:0] kind, input tag_t tag, input track_t track);
        logic [IN_DATA_BITS-1:0] word;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        word = '0;
        word[TAG_BITS-1:0] = tag;
        word[TAG_BITS +: TRACK_BITS] = track;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= word;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic add_request(input tag_t tag, input track_t track);
        send_request(REQ_ADD, tag, track);
    endtask

    task automatic get_request();
        send_request(REQ_GET, tag_t'($urandom), track_t'($urandom));
    endtask

    task automatic random_phase(input int add_pct);
        track_t trk;
        foreach (track_pool[k])
            track_pool[k] = track_t'($urandom);
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 3) != 0)
                trk = track_pool[$urandom_range(0, 3)];
            else
                trk = track_t'($urandom);
            if ($urandom_range(1, 100) <= add_pct)
                add_request(tag_t'($urandom), trk);
            else
                get_request();
        end
    endtask

    initial begin
        int add_pct;
        queue_model = new();
        burst_left = 0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_ADD;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty get, first adds, run ends, tail-only matches
        get_request();
        add_request('0, '0);
        add_request('1, '1);
        add_request(16'h0001, '0);
        add_request(16'h0002, '1);
        add_request(16'h0003, 10'h005);
        add_request(16'h0004, '1);
        add_request(16'h0005, 10'h005);
        add_request(16'hAAAA, 10'h155);
        add_request(16'h5555, 10'h2AA);
        add_request(16'h0006, '0);
        repeat (3) get_request();
        add_request(16'h0007, 10'h005);
        repeat (8) get_request();
        get_request();

        // random: fill-heavy and drain-heavy phases with mixed phases between them
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: add_pct = 96;
                2: add_pct = 8;
                default: add_pct = $urandom_range(30, 75);
            endcase
            random_phase(add_pct);
        end

        s_axis_tvalid <= 1'b0;
        while (queue_model.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (queue_model.errors == 0 && queue_model.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
